@@ rtl/boundary_tag_heap_allocator_defines.svh @@
// Assertion macros for the boundary-tag heap allocator.
// Included by the modules that check their own logic; no other dependencies.
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_DEFINES_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_DEFINES_SVH
`ifndef SYNTH
`define BTH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bth: implication check failed");
`define BTH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bth: next-cycle check failed");
`else
`define BTH_ASSERT_IMP(lbl, ante, cons)
`define BTH_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/bth_pkg.sv @@
// Shared constants for the boundary-tag heap allocator.
// No dependencies; used by the tag RAM and the top level.
package bth_pkg;

  // default geometry
  localparam int DEF_HEAP_BYTES    = 4096;
  localparam int DEF_GRANULE_BYTES = 8;

  // one tag word per granule
  localparam int WORD_BITS = 64;

  // port field widths
  localparam int CMD_W  = 1;
  localparam int SIZE_W = 12;
  localparam int ADDR_W = 12;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

  // status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

endpackage

@@ rtl/bth_tag_ram.sv @@
// Heap tag memory: one write port, one read port with registered read data.
// Depends on bth_pkg for the word width.
module bth_tag_ram #(
  parameter int DEPTH = 512
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(DEPTH)-1:0]      waddr,
  input  logic [bth_pkg::WORD_BITS-1:0] wdata,
  input  logic                          re,
  input  logic [$clog2(DEPTH)-1:0]      raddr,
  output logic [bth_pkg::WORD_BITS-1:0] rdata
);
  import bth_pkg::*;

  logic [WORD_BITS-1:0] mem_r [DEPTH];
  logic [WORD_BITS-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/boundary_tag_heap_allocator.sv @@
// Boundary-tag heap allocator with an address-ordered free list, first fit.
// Depends on bth_pkg, bth_tag_ram and boundary_tag_heap_allocator_defines.svh.
//
// Usage: present in_command, in_size_bytes and in_block_address with start
// high while busy is low; the item is taken at that clock edge. busy stays high
// until the result has been shown. Every item, allocate or free, yields exactly
// one result: out_valid is high for one cycle with out_status and
// out_payload_address. The receiver cannot hold the result off.
// The tag RAM gets at most one read or one write per state; a registered read
// takes a request state and a data state for each visited block. In order:
//   allocate: walk the free list; on a fit, write the split remainder's tags
//         if any, relink the list, then write the header and footer tags;
//   free: walk blocks from the heap start, walk the free blocks before it,
//         then checks and tag updates.
// Each list or block walk is capped at HEAP_BYTES / (3 * GRANULE_BYTES) + 2
// steps. A new item is taken the cycle after out_valid.
// Reset (rst_n low, synchronous) empties the free list and sets the bump
// pointer just past the three-granule sentinel; the tag memory is not cleared,
// no clearing pass is needed, and the block is ready right after reset.
`include "boundary_tag_heap_allocator_defines.svh"
module boundary_tag_heap_allocator #(
  parameter int HEAP_BYTES    = bth_pkg::DEF_HEAP_BYTES,
  parameter int GRANULE_BYTES = bth_pkg::DEF_GRANULE_BYTES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [bth_pkg::CMD_W-1:0]  in_command,
  input  logic [bth_pkg::SIZE_W-1:0] in_size_bytes,
  input  logic [bth_pkg::ADDR_W-1:0] in_block_address,
  output logic                       out_valid,
  output logic                       out_status,
  output logic [bth_pkg::ADDR_W-1:0] out_payload_address
);
  import bth_pkg::*;

  // geometry
  localparam int DEPTH      = HEAP_BYTES / GRANULE_BYTES;
  localparam int IW         = $clog2(DEPTH);
  localparam int GSH        = $clog2(GRANULE_BYTES);
  localparam int HLOG       = $clog2(HEAP_BYTES);
  localparam int AW         = ((HLOG > SIZE_W) ? HLOG : SIZE_W) + 2;
  localparam int WALK_LIMIT = HEAP_BYTES / (3 * GRANULE_BYTES) + 2;
  localparam int CW         = $clog2(WALK_LIMIT + 1);

  localparam logic [AW-1:0] G_A     = AW'(GRANULE_BYTES);
  localparam logic [AW-1:0] FIRST_A = AW'(3 * GRANULE_BYTES);
  localparam logic [AW-1:0] SPLIT_A = AW'(16 + 2 * GRANULE_BYTES);
  localparam logic [AW-1:0] HEAP_A  = AW'(HEAP_BYTES);
  localparam logic [AW-1:0] RND_A   = AW'(3 * GRANULE_BYTES - 1);
  localparam logic [AW-1:0] GMASK_A = ~AW'(GRANULE_BYTES - 1);
  localparam logic [CW-1:0] LIMIT_C = CW'(WALK_LIMIT);

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_ALOOK = 18'h00002,
    S_ATEST = 18'h00004,
    S_ALINK = 18'h00008,
    S_PUTH  = 18'h00010,
    S_PUTF  = 18'h00020,
    S_FWALK = 18'h00040,
    S_FWDAT = 18'h00080,
    S_FHDR  = 18'h00100,
    S_FLIST = 18'h00200,
    S_FLDAT = 18'h00400,
    S_FLINK = 18'h00800,
    S_FNREQ = 18'h01000,
    S_FNDAT = 18'h02000,
    S_FBREQ = 18'h04000,
    S_FBDAT = 18'h08000,
    S_DONE  = 18'h10000,
    S_SPARE = 18'h20000
  } state_t;

  // control state
  state_t          state_r, state_nxt;
  state_t          after_r, after_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [AW-1:0]   bump_r, bump_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  // working registers
  logic [AW-1:0]   cur_r, cur_nxt;
  logic [AW-1:0]   prev_r, prev_nxt;
  logic [AW-1:0]   prev_low_r, prev_low_nxt;
  logic [AW-1:0]   blk_r, blk_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;
  logic [AW-1:0]   req_r, req_nxt;
  logic [AW-1:0]   sz_r, sz_nxt;
  logic [AW-1:0]   link_r, link_nxt;
  logic [AW-1:0]   next_r, next_nxt;
  logic [AW-1:0]   wb_r, wb_nxt;
  logic [AW-1:0]   ws_r, ws_nxt;
  logic [AW-1:0]   wnext_r, wnext_nxt;
  logic            wused_r, wused_nxt;
  logic            status_r, status_nxt;
  logic [AW-1:0]   res_r, res_nxt;

  // tag RAM port
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_wa, mem_ra;
  logic [WORD_BITS-1:0] mem_wd, mem_rd;

  // fields of the word just read
  logic [AW-1:0] rd_size, rd_next;
  logic          rd_used;

  assign rd_size = {mem_rd[AW-1:1], 1'b0};
  assign rd_used = mem_rd[0];
  assign rd_next = mem_rd[32 +: AW];

  function automatic logic [WORD_BITS-1:0] mk_word(input logic [AW-1:0] nxt,
                                                  input logic [AW-1:0] size,
                                                  input logic          used);
    logic [WORD_BITS-1:0] w;
    w = (WORD_BITS'(nxt) << 32) | WORD_BITS'({size[AW-1:1], used});
    return w;
  endfunction

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    after_nxt    = after_r;
    head_nxt     = head_r;
    bump_nxt     = bump_r;
    cnt_nxt      = cnt_r;
    cur_nxt      = cur_r;
    prev_nxt     = prev_r;
    prev_low_nxt = prev_low_r;
    blk_nxt      = blk_r;
    pos_nxt      = pos_r;
    req_nxt      = req_r;
    sz_nxt       = sz_r;
    link_nxt     = link_r;
    next_nxt     = next_r;
    wb_nxt       = wb_r;
    ws_nxt       = ws_r;
    wnext_nxt    = wnext_r;
    wused_nxt    = wused_r;
    status_nxt   = status_r;
    res_nxt      = res_r;
    mem_we       = 1'b0;
    mem_wa       = wb_r;
    mem_wd       = mk_word(wnext_r, ws_r, wused_r);
    mem_re       = 1'b0;
    mem_ra       = cur_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          status_nxt = STATUS_OK;
          res_nxt    = '0;
          cnt_nxt    = '0;
          prev_nxt   = '0;
          if (in_command == CMD_ALLOC) begin
            cur_nxt = head_r;
            req_nxt = (AW'(in_size_bytes) + RND_A) & GMASK_A;
            if (in_size_bytes == '0) begin
              status_nxt = STATUS_FAIL;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_ALOOK;
            end
          end else begin
            blk_nxt = AW'(in_block_address) - G_A;
            pos_nxt = FIRST_A;
            if (AW'(in_block_address) < G_A) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_FWALK;
            end
          end
        end
      end

      // first-fit walk of the free list, else bump allocation
      S_ALOOK: begin
        if (cnt_r < LIMIT_C && cur_r != '0) begin
          mem_re    = 1'b1;
          mem_ra    = cur_r;
          state_nxt = S_ATEST;
        end else if (bump_r + req_r < HEAP_A) begin
          wb_nxt    = bump_r;
          ws_nxt    = req_r;
          wnext_nxt = '0;
          wused_nxt = 1'b1;
          after_nxt = S_DONE;
          res_nxt   = bump_r + G_A;
          bump_nxt  = bump_r + req_r;
          state_nxt = S_PUTH;
        end else begin
          status_nxt = STATUS_FAIL;
          state_nxt  = S_DONE;
        end
      end

      S_ATEST: begin
        if (rd_size >= req_r) begin
          res_nxt = cur_r + G_A;
          if (rd_size >= req_r + SPLIT_A) begin
            // split: remainder stays free and takes this block's list place
            wb_nxt    = cur_r + req_r;
            ws_nxt    = rd_size - req_r;
            wnext_nxt = rd_next;
            wused_nxt = 1'b0;
            link_nxt  = cur_r + req_r;
            after_nxt = S_ALINK;
            state_nxt = S_PUTH;
          end else begin
            req_nxt   = rd_size;
            link_nxt  = rd_next;
            state_nxt = S_ALINK;
          end
        end else begin
          prev_nxt     = cur_r;
          prev_low_nxt = mem_rd[AW-1:0];
          cur_nxt      = rd_next;
          cnt_nxt      = cnt_r + 1'b1;
          state_nxt    = S_ALOOK;
        end
      end

      S_ALINK: begin
        if (prev_r == '0) begin
          head_nxt = link_r;
        end else begin
          mem_we = 1'b1;
          mem_wa = prev_r;
          mem_wd = mk_word(link_r, prev_low_r, prev_low_r[0]);
        end
        wb_nxt    = cur_r;
        ws_nxt    = req_r;
        wnext_nxt = '0;
        wused_nxt = 1'b1;
        after_nxt = S_DONE;
        state_nxt = S_PUTH;
      end

      // header and footer tag writes
      S_PUTH: begin
        mem_we = 1'b1;
        mem_wa = wb_r;
        mem_wd = mk_word(wnext_r, ws_r, wused_r);
        if (ws_r >= G_A) begin
          state_nxt = S_PUTF;
        end else begin
          state_nxt = after_r;
        end
      end

      S_PUTF: begin
        mem_we    = 1'b1;
        mem_wa    = wb_r + ws_r - G_A;
        mem_wd    = mk_word('0, ws_r, wused_r);
        state_nxt = after_r;
      end

      // free: confirm the address by walking blocks from the heap start
      S_FWALK: begin
        if (cnt_r < LIMIT_C && pos_r < bump_r && pos_r != blk_r) begin
          mem_re    = 1'b1;
          mem_ra    = pos_r;
          state_nxt = S_FWDAT;
        end else if (pos_r != blk_r || pos_r >= bump_r) begin
          state_nxt = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_ra    = blk_r;
          state_nxt = S_FHDR;
        end
      end

      S_FWDAT: begin
        if (rd_size == '0) begin
          state_nxt = S_DONE;
        end else begin
          pos_nxt   = pos_r + rd_size;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_FWALK;
        end
      end

      S_FHDR: begin
        if (!rd_used) begin
          state_nxt = S_DONE;
        end else begin
          sz_nxt    = rd_size;
          prev_nxt  = '0;
          cur_nxt   = head_r;
          cnt_nxt   = '0;
          state_nxt = S_FLIST;
        end
      end

      // find the address-ordered insertion point
      S_FLIST: begin
        if (cnt_r < LIMIT_C && cur_r != '0 && cur_r < blk_r) begin
          mem_re    = 1'b1;
          mem_ra    = cur_r;
          state_nxt = S_FLDAT;
        end else begin
          wb_nxt    = blk_r;
          ws_nxt    = sz_r;
          wnext_nxt = cur_r;
          wused_nxt = 1'b0;
          next_nxt  = cur_r;
          after_nxt = S_FLINK;
          state_nxt = S_PUTH;
        end
      end

      S_FLDAT: begin
        prev_nxt     = cur_r;
        prev_low_nxt = mem_rd[AW-1:0];
        cur_nxt      = rd_next;
        cnt_nxt      = cnt_r + 1'b1;
        state_nxt    = S_FLIST;
      end

      S_FLINK: begin
        if (prev_r == '0) begin
          head_nxt = blk_r;
        end else begin
          mem_we = 1'b1;
          mem_wa = prev_r;
          mem_wd = mk_word(blk_r, prev_low_r, prev_low_r[0]);
        end
        state_nxt = S_FNREQ;
      end

      // merge with the following block
      S_FNREQ: begin
        if (blk_r + sz_r < bump_r) begin
          mem_re    = 1'b1;
          mem_ra    = blk_r + sz_r;
          state_nxt = S_FNDAT;
        end else begin
          state_nxt = S_FBREQ;
        end
      end

      S_FNDAT: begin
        if (!rd_used && rd_size != '0) begin
          sz_nxt    = sz_r + rd_size;
          next_nxt  = rd_next;
          wb_nxt    = blk_r;
          ws_nxt    = sz_r + rd_size;
          wnext_nxt = rd_next;
          wused_nxt = 1'b0;
          after_nxt = S_FBREQ;
          state_nxt = S_PUTH;
        end else begin
          state_nxt = S_FBREQ;
        end
      end

      // merge with the preceding block; the first block has none
      S_FBREQ: begin
        if (blk_r > FIRST_A) begin
          mem_re    = 1'b1;
          mem_ra    = blk_r - G_A;
          state_nxt = S_FBDAT;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_FBDAT: begin
        if (!rd_used && rd_size != '0 && rd_size <= blk_r - FIRST_A) begin
          wb_nxt    = blk_r - rd_size;
          ws_nxt    = rd_size + sz_r;
          wnext_nxt = next_r;
          wused_nxt = 1'b0;
          after_nxt = S_DONE;
          state_nxt = S_PUTH;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      after_r <= S_DONE;
      head_r  <= '0;
      bump_r  <= FIRST_A;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      head_r  <= head_nxt;
      bump_r  <= bump_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    prev_low_r <= prev_low_nxt;
    blk_r      <= blk_nxt;
    pos_r      <= pos_nxt;
    req_r      <= req_nxt;
    sz_r       <= sz_nxt;
    link_r     <= link_nxt;
    next_r     <= next_nxt;
    wb_r       <= wb_nxt;
    ws_r       <= ws_nxt;
    wnext_r    <= wnext_nxt;
    wused_r    <= wused_nxt;
    status_r   <= status_nxt;
    res_r      <= res_nxt;
  end

  // tag memory; writes past the heap end are dropped
  bth_tag_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we && (mem_wa < HEAP_A)),
    .waddr (mem_wa[GSH +: IW]),
    .wdata (mem_wd),
    .re    (mem_re),
    .raddr (mem_ra[GSH +: IW]),
    .rdata (mem_rd)
  );

  // outputs
  assign busy                = (state_r != S_IDLE);
  assign out_valid           = (state_r == S_DONE);
  assign out_status          = status_r;
  assign out_payload_address = res_r[ADDR_W-1:0];

  // checks
  `BTH_ASSERT_NXT(a_take_goes_busy, start && !busy, busy)
  `BTH_ASSERT_NXT(a_single_strobe, out_valid, !out_valid && !busy)
  `BTH_ASSERT_IMP(a_fail_is_null, out_valid && out_status, out_payload_address == '0)
  `BTH_ASSERT_IMP(a_bump_floor, !busy, bump_r >= FIRST_A && bump_r <= HEAP_A)
  `BTH_ASSERT_IMP(a_no_rw_collide, mem_we && mem_re, mem_wa != mem_ra)

endmodule
